[design/rrrp_pkg.sv]
// Shared types and constants for the round-robin register picker.
// No dependencies; compiled first.
package rrrp_pkg;

	localparam int NUM_REGS = 32;
	localparam int REG_W    = 5;
	localparam int OP_W     = 2;

	localparam logic [OP_W-1:0] OP_FIXED   = 2'd0;
	localparam logic [OP_W-1:0] OP_FLOAT   = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_MASK = 1'b1;

	localparam logic [NUM_REGS-1:0] FIXED_MASK_RESET = 32'h03ff_01ff;
	localparam logic [NUM_REGS-1:0] FLOAT_MASK_RESET = 32'h7fc0_fc00;

	localparam int TOP_REG_DEF    = 31;
	localparam int FLOAT_WRAP_DEF = 10;

	localparam logic [REG_W-1:0] FIXED_WRAP_START = 5'd1;
	localparam logic [REG_W-1:0] PTR_RESET        = 5'd1;

	// search window handed to every cell: (start, top] first, then [lo, hi]
	typedef struct packed {
		logic [REG_W-1:0] start;
		logic [REG_W-1:0] lo;
		logic [REG_W-1:0] hi;
	} search_t;

	// one flag per search window; used for both the ripple carry and the hits
	typedef struct packed {
		logic first;
		logic second;
	} flags_t;

endpackage

[design/rrrp_in_if.sv]
// Request channel: operation and exclusion mask with valid/ready.
// Depends on rrrp_pkg.
interface rrrp_in_if import rrrp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [NUM_REGS-1:0] exclude_mask;

	modport source(output valid, output operation, output exclude_mask, input ready);
	modport sink(input valid, input operation, input exclude_mask, output ready);
endinterface

[design/rrrp_out_if.sv]
// Response channel: chosen register and fail flag with valid/ready.
// Depends on rrrp_pkg.
interface rrrp_out_if import rrrp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REG_W-1:0] reg_number;
	logic             none_free;

	modport source(output valid, output reg_number, output none_free, input ready);
	modport sink(input valid, input reg_number, input none_free, output ready);
endinterface

[design/rrrp_cell.sv]
// One register position of the priority chain.
// Depends on rrrp_pkg.
module rrrp_cell import rrrp_pkg::*; #(
	parameter int IDX     = 0,
	parameter int TOP_REG = TOP_REG_DEF
) (
	input  logic    eligible,
	input  search_t srch,
	input  flags_t  found_in,
	output flags_t  found_out,
	output flags_t  hit
);

	localparam logic [REG_W-1:0] POS = REG_W'(IDX);
	localparam bit BELOW_TOP = (IDX <= TOP_REG);

	logic in_first;
	logic in_second;

	assign in_first  = BELOW_TOP && (POS > srch.start);
	assign in_second = (POS >= srch.lo) && (POS <= srch.hi);

	assign hit.first     = eligible & in_first & ~found_in.first;
	assign hit.second    = eligible & in_second & ~found_in.second;
	assign found_out.first  = found_in.first | hit.first;
	assign found_out.second = found_in.second | hit.second;

endmodule

[design/rrrp_row.sv]
// Row of cells, lowest position first, plus the encoder of the winning hit.
// Depends on rrrp_pkg and rrrp_cell.
module rrrp_row import rrrp_pkg::*; #(
	parameter int TOP_REG = TOP_REG_DEF
) (
	input  logic [NUM_REGS-1:0] eligible,
	input  search_t             srch,
	output logic                found,
	output logic [REG_W-1:0]    pick
);

	flags_t carry [0:NUM_REGS];
	flags_t hit   [0:NUM_REGS-1];

	assign carry[0] = '0;

	for (genvar i = 0; i < NUM_REGS; i++) begin : g_cell
		rrrp_cell #(
			.IDX     (i),
			.TOP_REG (TOP_REG)
		) u_cell (
			.eligible  (eligible[i]),
			.srch      (srch),
			.found_in  (carry[i]),
			.found_out (carry[i+1]),
			.hit       (hit[i])
		);
	end

	logic [REG_W-1:0] idx_first;
	logic [REG_W-1:0] idx_second;

	// hits are one-hot per window, so an OR of the positions encodes them
	always_comb begin
		idx_first  = '0;
		idx_second = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (hit[i].first)
				idx_first = idx_first | REG_W'(i);
			if (hit[i].second)
				idx_second = idx_second | REG_W'(i);
		end
	end

	assign found = carry[NUM_REGS].first | carry[NUM_REGS].second;
	assign pick  = carry[NUM_REGS].first ? idx_first : idx_second;

endmodule

[design/round_robin_register_picker.sv]
// Round-robin free register picker, fixed and float classes.
// Timing: the response is registered, so response valid rises in the cycle after the request beat is accepted.
// Throughput: one request beat per cycle while responses drain; a stalled response holds
// off the request side until it leaves. The pick resolves in a 32-cell ripple chain.
// Reset: masks take their default values, both pointers go to 1, no response pending.
// Depends on rrrp_pkg, rrrp_in_if, rrrp_out_if, rrrp_row.
module round_robin_register_picker import rrrp_pkg::*; #(
	parameter int TOP_REG          = TOP_REG_DEF,
	parameter int FLOAT_WRAP_START = FLOAT_WRAP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_REGS-1:0]  cfg_data,
	rrrp_in_if.sink              req,
	rrrp_out_if.source           rsp
);

	localparam logic [REG_W-1:0] FLOAT_LO = REG_W'(FLOAT_WRAP_START);

	logic [NUM_REGS-1:0] fixed_mask_q;
	logic [NUM_REGS-1:0] float_mask_q;
	logic [REG_W-1:0]    fixed_ptr_q;
	logic [REG_W-1:0]    float_ptr_q;
	logic                rsp_valid_q;
	logic [REG_W-1:0]    reg_number_q;
	logic                none_free_q;

	logic                is_float;
	logic                is_pick;
	logic                accept;
	logic [NUM_REGS-1:0] eligible;
	search_t             srch;
	logic                found;
	logic [REG_W-1:0]    pick;

	assign is_float = (req.operation == OP_FLOAT);
	assign is_pick  = (req.operation == OP_FIXED) || is_float;
	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign accept   = req.valid & req.ready;

	// second window runs from the wrap start up to the pointer (or the wrap start alone)
	always_comb begin
		srch.start = is_float ? float_ptr_q : fixed_ptr_q;
		srch.lo    = is_float ? FLOAT_LO : FIXED_WRAP_START;
		srch.hi    = (srch.start >= srch.lo) ? srch.start : srch.lo;
		eligible   = (is_float ? float_mask_q : fixed_mask_q) & ~req.exclude_mask;
	end

	rrrp_row #(
		.TOP_REG (TOP_REG)
	) u_row (
		.eligible (eligible),
		.srch     (srch),
		.found    (found),
		.pick     (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_mask_q <= FIXED_MASK_RESET;
			float_mask_q <= FLOAT_MASK_RESET;
			fixed_ptr_q  <= PTR_RESET;
			float_ptr_q  <= PTR_RESET;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FIXED_MASK: fixed_mask_q <= cfg_data;
					CFG_FLOAT_MASK: float_mask_q <= cfg_data;
				endcase
			end
			if (accept) begin
				unique case (req.operation)
					OP_FIXED: begin
						if (found)
							fixed_ptr_q <= pick;
					end
					OP_FLOAT: begin
						if (found)
							float_ptr_q <= pick;
					end
					OP_RESTART: begin
						fixed_ptr_q <= PTR_RESET;
						float_ptr_q <= PTR_RESET;
					end
					default: ;
				endcase
			end
			if (accept)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reg_number_q <= (is_pick && found) ? pick : '0;
			none_free_q  <= is_pick && !found;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.reg_number = reg_number_q;
	assign rsp.none_free  = none_free_q;

endmodule
